>>> rtl/core/kslp_pkg.sv
// Shared types and constants for the key short/long press classifier.
// Used by every module of the block; depends on nothing.

package kslp_pkg;

	// Fixed widths of the item fields and of the configuration registers.
	localparam int FIELD_W = 16;
	localparam int REG_W   = 10;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register reset values.
	localparam logic [REG_W-1:0] SHORT_RESET  = 10'd4;
	localparam logic [REG_W-1:0] LONG_RESET   = 10'd200;
	localparam logic [REG_W-1:0] THRESH_RESET = 10'd160;

	// Register indexes (byte address divided by four).
	typedef enum logic [1:0] {
		REG_SHORT  = 2'd0,
		REG_LONG   = 2'd1,
		REG_THRESH = 2'd2
	} reg_idx_t;

	// Configuration seen by every lane.
	typedef struct packed {
		logic [REG_W-1:0] short_ticks;
		logic [REG_W-1:0] long_ticks;
		logic [REG_W-1:0] threshold_ticks;
	} cfg_t;

	// Events that one lane reports for the current item.
	typedef struct packed {
		logic short_ev;
		logic long_ev;
	} lane_evt_t;

	// One result item.
	typedef struct packed {
		logic [FIELD_W-1:0] short_events;
		logic [FIELD_W-1:0] long_events;
		logic [FIELD_W-1:0] short_sticky;
		logic [FIELD_W-1:0] long_sticky;
	} res_t;

endpackage

>>> rtl/core/kslp_lane.sv
// One key lane: hold counter, pending-short mark and event decode.
// Depends on kslp_pkg.

module kslp_lane #(
	parameter int COUNT_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                held,
	input  kslp_pkg::cfg_t      cfg,
	output kslp_pkg::lane_evt_t evt
);

	localparam int CW = ((COUNT_BITS > kslp_pkg::REG_W) ? COUNT_BITS : kslp_pkg::REG_W) + 1;
	localparam logic [CW-1:0] COUNT_MAX = {{(CW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

	logic [COUNT_BITS-1:0] hold_q;
	logic                  pend_q;
	logic [COUNT_BITS-1:0] hold_d;
	logic                  pend_d;
	logic [CW-1:0]         inc;
	logic [CW-1:0]         sat;
	logic [CW-1:0]         cnt;
	logic [CW-1:0]         long_x;

	always_comb begin
		long_x = CW'(cfg.long_ticks);
		inc    = CW'(hold_q) + CW'(1);
		sat    = (inc > long_x) ? (long_x + CW'(1)) : inc;
		cnt    = (sat > COUNT_MAX) ? COUNT_MAX : sat;

		hold_d       = hold_q;
		pend_d       = pend_q;
		evt.short_ev = 1'b0;
		evt.long_ev  = 1'b0;
		if (held) begin
			hold_d = cnt[COUNT_BITS-1:0];
			if (cnt == long_x) begin
				pend_d      = 1'b0;
				evt.long_ev = 1'b1;
			end else if (cnt == CW'(cfg.short_ticks)) begin
				pend_d = 1'b1;
			end
		end else if ((CW'(hold_q) < CW'(cfg.threshold_ticks)) && pend_q) begin
			// Short press: the count stays until the next released tick.
			pend_d       = 1'b0;
			evt.short_ev = 1'b1;
		end else begin
			hold_d = '0;
			pend_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			pend_q <= 1'b0;
		end else if (en) begin
			hold_q <= hold_d;
			pend_q <= pend_d;
		end
	end

endmodule

>>> rtl/core/kslp_merge.sv
// Merging stage: sticky flags, result assembly and a two-entry output buffer.
// Depends on kslp_pkg.

module kslp_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kslp_pkg::FIELD_W-1:0]  short_clear,
	input  logic [kslp_pkg::FIELD_W-1:0]  long_clear,
	input  logic [kslp_pkg::FIELD_W-1:0]  short_ev,
	input  logic [kslp_pkg::FIELD_W-1:0]  long_ev,
	output logic                          accept,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kslp_pkg::res_t                res
);

	logic [kslp_pkg::FIELD_W-1:0] short_flags_q;
	logic [kslp_pkg::FIELD_W-1:0] long_flags_q;
	kslp_pkg::res_t               new_res;
	kslp_pkg::res_t               res_s1;
	logic                         res_v_s1;
	kslp_pkg::res_t               skid_q;
	logic                         skid_v_q;
	logic                         take;

	assign in_stall = skid_v_q;
	assign accept   = in_valid & ~skid_v_q;
	assign take     = res_v_s1 & ~out_stall;

	always_comb begin
		new_res.short_events = short_ev;
		new_res.long_events  = long_ev;
		new_res.short_sticky = (short_flags_q & ~short_clear) | short_ev;
		new_res.long_sticky  = (long_flags_q & ~long_clear) | long_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_flags_q <= '0;
			long_flags_q  <= '0;
		end else if (accept) begin
			short_flags_q <= new_res.short_sticky;
			long_flags_q  <= new_res.long_sticky;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1 <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					res_v_s1 <= accept;
				end
			end else if (accept) begin
				if (res_v_s1) begin
					skid_v_q <= 1'b1;
				end else begin
					res_v_s1 <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_v_q) begin
			res_s1 <= skid_q;
		end else if (accept && (take || !res_v_s1)) begin
			res_s1 <= new_res;
		end
		if (accept && res_v_s1 && !take) begin
			skid_q <= new_res;
		end
	end

	assign out_valid = res_v_s1;
	assign res       = res_s1;

endmodule

>>> rtl/core/key_short_long_press_classifier.sv
// Top level of the key short/long press classifier: register port, key lanes and merge stage.
// Depends on kslp_pkg, kslp_lane and kslp_merge.
// A result item is registered in the output buffer when its scan item is accepted.
// Throughput: one item per cycle unless in_stall is high; key lanes update on each accepted item.
// A two-entry output buffer lets input continue one item past a stalled output.
// Reset (arst_n low, asynchronous) clears counters, marks, sticky flags and buffers
// and loads the register defaults; no clearing pass is needed.

module key_short_long_press_classifier #(
	parameter int NUM_KEYS   = 16,
	parameter int COUNT_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Register port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kslp_pkg::ADDR_W-1:0]   paddr,
	input  logic [kslp_pkg::DATA_W-1:0]   pwdata,
	output logic [kslp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// Scan item input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kslp_pkg::FIELD_W-1:0]  key_levels,
	input  logic [kslp_pkg::FIELD_W-1:0]  short_clear,
	input  logic [kslp_pkg::FIELD_W-1:0]  long_clear,
	// Result item output channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kslp_pkg::FIELD_W-1:0]  short_events,
	output logic [kslp_pkg::FIELD_W-1:0]  long_events,
	output logic [kslp_pkg::FIELD_W-1:0]  short_sticky,
	output logic [kslp_pkg::FIELD_W-1:0]  long_sticky
);

	// Keys past the level field are never held, so they can never report
	// an event; only the keys that have a level bit get a lane.
	localparam int LANES = (NUM_KEYS < kslp_pkg::FIELD_W) ? NUM_KEYS : kslp_pkg::FIELD_W;

	kslp_pkg::cfg_t               cfg_q;
	kslp_pkg::reg_idx_t           reg_idx;
	logic                         wr_en;
	logic                         accept;
	logic [kslp_pkg::FIELD_W-1:0] short_ev;
	logic [kslp_pkg::FIELD_W-1:0] long_ev;
	kslp_pkg::lane_evt_t          evt [LANES];
	kslp_pkg::res_t               res;

	// Register port. Writes complete in the access phase; the port never waits.
	assign pready  = 1'b1;
	assign reg_idx = kslp_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_ticks     <= kslp_pkg::SHORT_RESET;
			cfg_q.long_ticks      <= kslp_pkg::LONG_RESET;
			cfg_q.threshold_ticks <= kslp_pkg::THRESH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				kslp_pkg::REG_SHORT: begin
					cfg_q.short_ticks <= pwdata[kslp_pkg::REG_W-1:0];
				end
				kslp_pkg::REG_LONG: begin
					cfg_q.long_ticks <= pwdata[kslp_pkg::REG_W-1:0];
				end
				kslp_pkg::REG_THRESH: begin
					cfg_q.threshold_ticks <= pwdata[kslp_pkg::REG_W-1:0];
				end
				default: begin
					// Addresses past the register list take no write.
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			kslp_pkg::REG_SHORT:  prdata = kslp_pkg::DATA_W'(cfg_q.short_ticks);
			kslp_pkg::REG_LONG:   prdata = kslp_pkg::DATA_W'(cfg_q.long_ticks);
			kslp_pkg::REG_THRESH: prdata = kslp_pkg::DATA_W'(cfg_q.threshold_ticks);
			default:              prdata = '0;
		endcase
	end

	// One lane per key. Each lane advances its state only when the item is accepted,
	// and reports its events for that item combinationally to the merge stage.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		kslp_lane #(
			.COUNT_BITS(COUNT_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (accept),
			.held  (key_levels[g]),
			.cfg   (cfg_q),
			.evt   (evt[g])
		);
		assign short_ev[g] = evt[g].short_ev;
		assign long_ev[g]  = evt[g].long_ev;
	end

	// Event bits of keys without a lane are always clear.
	for (genvar g = LANES; g < kslp_pkg::FIELD_W; g++) begin : g_nolane
		assign short_ev[g] = 1'b0;
		assign long_ev[g]  = 1'b0;
	end

	// The merge stage folds the lane events into the sticky flags and holds
	// the result item until the output side takes it.
	kslp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.short_clear(short_clear),
		.long_clear (long_clear),
		.short_ev   (short_ev),
		.long_ev    (long_ev),
		.accept     (accept),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	assign short_events = res.short_events;
	assign long_events  = res.long_events;
	assign short_sticky = res.short_sticky;
	assign long_sticky  = res.long_sticky;

endmodule

>>> rtl/core/kslp_checker.sv
// Port-level checks for the key short/long press classifier, bound to its top level.
// Depends on kslp_pkg and key_short_long_press_classifier.

module kslp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [kslp_pkg::FIELD_W-1:0]  short_events,
	input logic [kslp_pkg::FIELD_W-1:0]  long_events,
	input logic [kslp_pkg::FIELD_W-1:0]  short_sticky,
	input logic [kslp_pkg::FIELD_W-1:0]  long_sticky
);

	// Input only stalls while a result item is waiting at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// A key is either held or released on a tick, never both kinds of event.
	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((short_events & long_events) == '0))
		else $error("short and long event on the same key");

	// Every event of an item is also in that item's sticky flags.
	a_events_in_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((short_events & ~short_sticky) == '0) &&
			((long_events & ~long_sticky) == '0)))
		else $error("event missing from sticky flags");

	// A stalled result item stays valid and keeps its sticky flags.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(short_sticky) &&
			$stable(long_sticky)))
		else $error("stalled result changed");

endmodule

bind key_short_long_press_classifier kslp_checker u_kslp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.short_events(short_events),
	.long_events (long_events),
	.short_sticky(short_sticky),
	.long_sticky (long_sticky)
);

>>> tb/kslp_press_sb_pkg.sv
// Scoreboard for the key short/long press classifier testbench: a cycle-free predictor
// of the per-key hold counters and sticky flags, plus the queue of expected result items.
// Depends on kslp_pkg for the result item type and the register reset values.

package kslp_press_sb_pkg;

	import kslp_pkg::*;

	localparam int          KEYS           = 16;
	localparam int          CNT_BITS       = 10;
	localparam int unsigned CNT_MAX        = (1 << CNT_BITS) - 1;
	localparam int unsigned REG_MASK       = (1 << REG_W) - 1;
	localparam int unsigned UNUSED_REG_IDX = 3;

	class press_scoreboard;

		int unsigned        short_ticks;
		int unsigned        long_ticks;
		int unsigned        thresh_ticks;
		int unsigned        hold_cnt[KEYS];
		bit                 pend[KEYS];
		logic [FIELD_W-1:0] short_flags;
		logic [FIELD_W-1:0] long_flags;
		res_t               expected_q[$];
		int unsigned        scans;
		int unsigned        checked;
		int unsigned        mismatches;

		function new();
			short_ticks  = SHORT_RESET;
			long_ticks   = LONG_RESET;
			thresh_ticks = THRESH_RESET;
			foreach (hold_cnt[k]) begin
				hold_cnt[k] = 0;
				pend[k]     = 1'b0;
			end
			short_flags = '0;
			long_flags  = '0;
			scans       = 0;
			checked     = 0;
			mismatches  = 0;
		endfunction

		// Only the low register bits are kept; indexes past the list are ignored.
		function void write_reg(int unsigned idx, logic [31:0] value);
			int unsigned v;
			v = value & REG_MASK;
			if (idx == int'(REG_SHORT)) short_ticks = v;
			else if (idx == int'(REG_LONG)) long_ticks = v;
			else if (idx == int'(REG_THRESH)) thresh_ticks = v;
		endfunction

		function int unsigned reg_value(int unsigned idx);
			if (idx == int'(REG_SHORT)) return short_ticks;
			if (idx == int'(REG_LONG)) return long_ticks;
			return thresh_ticks;
		endfunction

		// Advances every key by one scan tick and queues the result item it causes.
		function void note_scan(logic [FIELD_W-1:0] levels, logic [FIELD_W-1:0] sclr,
				logic [FIELD_W-1:0] lclr);
			res_t        want;
			int unsigned c;
			want = '0;
			short_flags &= ~sclr;
			long_flags  &= ~lclr;
			for (int k = 0; k < KEYS; k++) begin
				if (levels[k]) begin
					c = hold_cnt[k] + 1;
					if (c > long_ticks) c = long_ticks + 1;
					if (c > CNT_MAX) c = CNT_MAX;
					hold_cnt[k] = c;
					if (c == short_ticks) pend[k] = 1'b1;
					if (c == long_ticks) begin
						pend[k] = 1'b0;
						want.long_events[k] = 1'b1;
					end
				end else if (hold_cnt[k] < thresh_ticks && pend[k]) begin
					// The count survives a short report until the next released tick.
					pend[k] = 1'b0;
					want.short_events[k] = 1'b1;
				end else begin
					hold_cnt[k] = 0;
					pend[k]     = 1'b0;
				end
			end
			short_flags |= want.short_events;
			long_flags  |= want.long_events;
			want.short_sticky = short_flags;
			want.long_sticky  = long_flags;
			expected_q.push_back(want);
			scans++;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("result item %h arrived with no scan item outstanding", got);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.short_events !== want.short_events) begin
				$error("short_events expected %h actual %h", want.short_events, got.short_events);
				mismatches++;
			end
			if (got.long_events !== want.long_events) begin
				$error("long_events expected %h actual %h", want.long_events, got.long_events);
				mismatches++;
			end
			if (got.short_sticky !== want.short_sticky) begin
				$error("short_sticky expected %h actual %h", want.short_sticky, got.short_sticky);
				mismatches++;
			end
			if (got.long_sticky !== want.long_sticky) begin
				$error("long_sticky expected %h actual %h", want.long_sticky, got.long_sticky);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

	endclass

endpackage

>>> tb/tb_key_short_long_press_classifier.sv
// Testbench for the key short/long press classifier: drives scan items and register
// writes, predicts every result item and checks it. Depends on kslp_pkg and kslp_press_sb_pkg.

module tb_key_short_long_press_classifier;

	import kslp_pkg::*;
	import kslp_press_sb_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 8;
	localparam int MAX_WAIT     = 8;
	// Output hold-off long enough to fill the output buffer and push back on the input.
	localparam int LONG_HOLD    = 64;
	// Settling time after the last expected result item has been taken.
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 400000;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [FIELD_W-1:0]  key_levels;
	logic [FIELD_W-1:0]  short_clear;
	logic [FIELD_W-1:0]  long_clear;
	logic                out_valid;
	logic                out_stall;
	logic [FIELD_W-1:0]  short_events;
	logic [FIELD_W-1:0]  long_events;
	logic [FIELD_W-1:0]  short_sticky;
	logic [FIELD_W-1:0]  long_sticky;

	press_scoreboard sb;

	// Idle stretch bookkeeping for the sender and the receiver. Each side alternates
	// between stretches where it idles at random and stretches where it never idles.
	int          snd_left;
	int          rcv_left;
	bit          snd_idle;
	bit          rcv_idle;
	// When rush is set the sender offers items back to back.
	bit          rush;
	// Set by the main sequence to ask the receiver for one long hold-off.
	bit          long_hold_req;
	int          cfg_errs;
	int          settings_seen;
	int unsigned cycle_cnt = 0;

	key_short_long_press_classifier #(
		.NUM_KEYS   (KEYS),
		.COUNT_BITS (CNT_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_levels   (key_levels),
		.short_clear  (short_clear),
		.long_clear   (long_clear),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.short_events (short_events),
		.long_events  (long_events),
		.short_sticky (short_sticky),
		.long_sticky  (long_sticky)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result monitor. Outputs are sampled at the rising edge, before the block updates them,
	// and out_stall only changes at the falling edge, so the accept decision is stable.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && !out_stall)
			sb.check_result(res_t'({short_events, long_events, short_sticky, long_sticky}));
	end

	// Returns how many cycles a side waits before its next item.
	function automatic int draw_wait(inout int left, inout bit idle);
		if (left == 0) begin
			left = $urandom_range(10, 60);
			idle = ($urandom_range(0, 3) != 0);
		end
		left--;
		return idle ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	// Receiver. For every result item it draws a stall, then drops out_stall until a
	// result is taken. On request it first holds out_stall high in one long hold-off.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			n = draw_wait(rcv_left, rcv_idle);
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Offers one scan item and returns at the falling edge after it was accepted.
	// Called at a falling edge; valid stays high across back-to-back items.
	task automatic send_scan(logic [FIELD_W-1:0] lv, logic [FIELD_W-1:0] sc,
			logic [FIELD_W-1:0] lc);
		int gap;
		gap = draw_wait(snd_left, snd_idle);
		if (rush) gap = 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		key_levels  = lv;
		short_clear = sc;
		long_clear  = lc;
		do @(posedge clk); while (in_stall);
		sb.note_scan(lv, sc, lc);
		@(negedge clk);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic reg_access(bit wr, int unsigned idx, logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = ADDR_W'(idx << 2);
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Waits until every expected result item has been taken, then lets the block settle.
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes all three thresholds plus the unused slot, then reads the thresholds back.
	// Only called while the block is idle.
	task automatic program_regs(logic [DATA_W-1:0] s, logic [DATA_W-1:0] l,
			logic [DATA_W-1:0] t);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		reg_access(1'b1, REG_SHORT, s, rd);
		sb.write_reg(REG_SHORT, s);
		reg_access(1'b1, REG_LONG, l, rd);
		sb.write_reg(REG_LONG, l);
		reg_access(1'b1, REG_THRESH, t, rd);
		sb.write_reg(REG_THRESH, t);
		// A write past the register list must leave every threshold alone.
		reg_access(1'b1, UNUSED_REG_IDX, junk, rd);
		sb.write_reg(UNUSED_REG_IDX, junk);
		for (int unsigned i = REG_SHORT; i <= REG_THRESH; i++) begin
			reg_access(1'b0, i, '0, rd);
			if (rd !== DATA_W'(sb.reg_value(i))) begin
				$error("prdata of register %0d expected %h actual %h", i,
					DATA_W'(sb.reg_value(i)), rd);
				cfg_errs++;
			end
		end
		settings_seen++;
	endtask

	// Length of one press. Most presses land near the short, threshold or long counts,
	// where the interesting decisions are made; the rest are spread up to max_run.
	function automatic int press_len(int max_run);
		int s;
		int l;
		int t;
		s = sb.short_ticks;
		l = sb.long_ticks;
		t = sb.thresh_ticks;
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, s + 2);
			1: return $urandom_range((t > 2) ? t - 2 : 1, t + 2);
			2: return $urandom_range((l > 2) ? l - 2 : 1, l + 3);
			default: return $urandom_range(1, max_run);
		endcase
	endfunction

	// Releases are mostly one or two ticks, so a key is often pressed again while the
	// count kept from a short report is still there.
	function automatic int release_len();
		if ($urandom_range(0, 3) == 0) return $urandom_range(1, 20);
		return $urandom_range(1, 2);
	endfunction

	// Random scan items: every key follows its own press/release pattern, with the odd
	// tick of pure noise on the levels and occasional sticky clears.
	task automatic run_random(int n, int max_run);
		bit                 held[KEYS];
		int                 run_left[KEYS];
		logic [FIELD_W-1:0] lv;
		logic [FIELD_W-1:0] sc;
		logic [FIELD_W-1:0] lc;
		for (int k = 0; k < KEYS; k++) begin
			held[k]     = $urandom_range(0, 1);
			run_left[k] = $urandom_range(0, 3);
		end
		repeat (n) begin
			for (int k = 0; k < KEYS; k++) begin
				if (run_left[k] == 0) begin
					held[k]     = !held[k];
					run_left[k] = held[k] ? press_len(max_run) : release_len();
				end
				run_left[k]--;
				lv[k] = held[k];
			end
			if ($urandom_range(0, 9) == 0) lv = FIELD_W'($urandom);
			case ($urandom_range(0, 9))
				6, 7: begin
					sc = FIELD_W'($urandom);
					lc = FIELD_W'($urandom);
				end
				8: begin
					sc = '1;
					lc = FIELD_W'($urandom);
				end
				9: begin
					sc = FIELD_W'($urandom);
					lc = '1;
				end
				default: begin
					sc = '0;
					lc = '0;
				end
			endcase
			send_scan(lv, sc, lc);
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		key_levels    = '0;
		short_clear   = '0;
		long_clear    = '0;
		snd_left      = 0;
		rcv_left      = 0;
		snd_idle      = 1'b0;
		rcv_idle      = 1'b0;
		rush          = 1'b0;
		long_hold_req = 1'b0;
		cfg_errs      = 0;
		settings_seen = 1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Reset thresholds (4, 200, 160): presses long enough to reach the long report.
		run_random(400, 260);
		settle();

		// Small thresholds so that every decision is reached within a few ticks.
		program_regs(32'd2, 32'd5, 32'd4);
		send_scan(16'h0000, 16'h0000, 16'h0000);
		// All keys held past the long count; the count then sits at its ceiling.
		repeat (7) send_scan(16'hFFFF, 16'h0000, 16'h0000);
		// Release after a long press: no short report.
		send_scan(16'h0000, 16'h0000, 16'h0000);
		// Low byte held three ticks: the pending mark is set, release reports short.
		repeat (3) send_scan(16'h00FF, 16'h0000, 16'h0000);
		send_scan(16'h0F00, 16'h0000, 16'h0000);
		// Keys 0-3 pressed again on top of the count kept from their short report,
		// keys 4-7 stay released and lose it.
		send_scan(16'h0F0F, 16'h0000, 16'h0000);
		send_scan(16'h0000, 16'h0000, 16'h0000);
		// Sticky clears: partial, full, and alternating patterns together with levels.
		send_scan(16'h0000, 16'h00F0, 16'hFFFF);
		send_scan(16'hAAAA, 16'hFFFF, 16'h0000);
		send_scan(16'h5555, 16'hAAAA, 16'h5555);
		send_scan(16'h0000, 16'h5555, 16'hAAAA);
		run_random(200, 12);
		settle();

		// Smallest short and long counts; a zero threshold never allows a short report.
		program_regs(32'd1, 32'd2, 32'd0);
		run_random(150, 8);
		settle();

		// Short equal to long: only the long report may appear.
		program_regs(32'd3, 32'd3, 32'd1023);
		run_random(150, 10);
		settle();

		// High data bits are dropped, leaving short and long at zero.
		program_regs(32'hABCD_E400, 32'h0000_FC00, 32'd500);
		run_random(150, 10);
		settle();

		// Largest long count: the counter must stop at its all-ones ceiling.
		program_regs(32'd1000, 32'd1023, 32'd1023);
		run_random(1100, 1100);
		settle();

		// Back-to-back items against a long output hold-off, so the block fills and
		// stalls its input.
		program_regs(32'd7, 32'd40, 32'd20);
		rush          = 1'b1;
		long_hold_req = 1'b1;
		run_random(200, 60);
		rush = 1'b0;
		settle();

		$display("Checked %0d result items from %0d scan items under %0d threshold settings,",
			sb.checked, sb.scans, settings_seen);
		$display("with random idling on both sides and one %0d-cycle output hold-off.",
			LONG_HOLD);
		if (sb.mismatches == 0 && cfg_errs == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
